>>> design/pfdr_pkg.sv
// ----------------------------------------------------------------------------
// pfdr_pkg
// Shared types and codes of the page frame store with dirty-rectangle tracking.
// ----------------------------------------------------------------------------
package pfdr_pkg;

	localparam int PAGE_ROWS = 8;

	typedef logic [PAGE_ROWS-1:0] byte_t;

	localparam byte_t FILL_BYTE = 8'h00;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_READ    = 2'd1,
		OP_REFRESH = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_PIXEL = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_IDLE  = 2'd2,
		KIND_FILL  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_READ  = 3'b100
	} state_t;

endpackage

>>> design/pfdr_store.sv
// ----------------------------------------------------------------------------
// pfdr_store
// Frame store: one write port, one read port, read data registered and held.
// ----------------------------------------------------------------------------
module pfdr_store #(
	parameter int DEPTH = 1024
) (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output pfdr_pkg::byte_t           rd_data,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  pfdr_pkg::byte_t           wr_data
);

	pfdr_pkg::byte_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/page_framebuffer_dirty_rect.sv
// ----------------------------------------------------------------------------
// page_framebuffer_dirty_rect
// Monochrome page-organised frame store with dirty-rectangle refresh drain.
// ----------------------------------------------------------------------------
// The store is read in the cycle a request is accepted, and the result (or the
// read-modify-write of a pixel) follows in the read state, where a result waits
// while the output register is full; the single store port lets a new request
// in only once the read state of the last one has ended. A clear zeroes the
// store by sweeping it one byte per cycle, then returns its fill result; the
// same sweep runs after reset and no request is accepted meanwhile. Results sit
// in an output register, so a request is accepted while the previous result
// still waits. SCREEN_HEIGHT is taken as a multiple of 8.
// ----------------------------------------------------------------------------
module page_framebuffer_dirty_rect #(
	parameter int SCREEN_WIDTH  = 128,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // pos_x[7:0], pos_y[14:8], color[15]
	input  logic [1:0]  s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // pixel, data_byte, column, page, new_row, zero pad
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast   // last
);

	localparam int PG    = SCREEN_HEIGHT / pfdr_pkg::PAGE_ROWS;
	localparam int DEPTH = SCREEN_WIDTH * PG;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(SCREEN_WIDTH);
	localparam int PW    = (PG > 1) ? $clog2(PG) : 1;

	localparam logic [CW-1:0] COL_LAST  = CW'(SCREEN_WIDTH - 1);
	localparam logic [PW-1:0] PAGE_LAST = PW'(PG - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] col,
	                                          input logic [PW-1:0] pg);
		return AW'(AW'(col) * AW'(PG) + AW'(pg));
	endfunction

	pfdr_pkg::state_t state_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             clr_report_q;

	logic [PW-1:0] dirty_fp_q, dirty_lp_q;
	logic [CW-1:0] dirty_fc_q, dirty_lc_q;
	logic          busy_q;
	logic [PW-1:0] drain_fp_q, drain_lp_q, drain_page_q;
	logic [CW-1:0] drain_fc_q, drain_lc_q, drain_col_q;

	pfdr_pkg::op_t   op_q;
	logic [2:0]      y_lo_q;
	logic            color_q;
	logic            inside_q;
	logic            empty_q;
	logic [AW-1:0]   addr_q;

	logic            out_valid_q;
	pfdr_pkg::kind_t out_kind_q;
	logic            out_pixel_q;
	pfdr_pkg::byte_t out_byte_q;
	logic [6:0]      out_col_q;
	logic [2:0]      out_page_q;
	logic            out_new_row_q;
	logic            out_last_q;

	pfdr_pkg::op_t   in_op;
	logic [7:0]      in_x;
	logic [6:0]      in_y;
	logic            in_color;
	logic            in_inside;
	logic [CW-1:0]   in_col;
	logic [PW-1:0]   in_pg;
	logic            accept;
	logic            dirty_empty;
	logic            out_free;
	logic            emit;
	logic            fin;
	logic            row_start;
	logic [7:0]      col_ext;
	logic [7:0]      page_ext;

	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	pfdr_pkg::byte_t rd_data;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	pfdr_pkg::byte_t wr_data;
	pfdr_pkg::byte_t bit_mask;

	assign in_op     = pfdr_pkg::op_t'(s_axis_tuser);
	assign in_x      = s_axis_tdata[7:0];
	assign in_y      = s_axis_tdata[14:8];
	assign in_color  = s_axis_tdata[15];
	assign in_inside = ({1'b0, in_x} < 9'(SCREEN_WIDTH)) && ({1'b0, in_y} < 8'(SCREEN_HEIGHT));
	assign in_col    = CW'(in_x);
	assign in_pg     = PW'(in_y >> 3);

	assign s_axis_tready = (state_q == pfdr_pkg::S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign dirty_empty   = (dirty_fp_q > dirty_lp_q) || (dirty_fc_q > dirty_lc_q);
	assign out_free      = !out_valid_q || m_axis_tready;
	assign emit          = (state_q == pfdr_pkg::S_READ) && (op_q != pfdr_pkg::OP_WRITE)
	                       && out_free;

	assign row_start = (drain_col_q == drain_fc_q);
	assign fin       = (drain_page_q == drain_lp_q) && (drain_col_q == drain_lc_q);
	assign col_ext   = 8'(drain_col_q);
	assign page_ext  = 8'(drain_page_q);

	// store read at accept
	always_comb begin
		rd_en   = accept;
		rd_addr = addr_of(in_col, in_pg);
		if (in_op == pfdr_pkg::OP_REFRESH) begin
			rd_addr = busy_q ? addr_of(drain_col_q, drain_page_q)
			                 : addr_of(dirty_fc_q, dirty_fp_q);
		end
	end

	// sweep or pixel write-back
	always_comb begin
		bit_mask = pfdr_pkg::byte_t'(1) << y_lo_q;
		wr_en    = 1'b0;
		wr_addr  = addr_q;
		wr_data  = color_q ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
		if (state_q == pfdr_pkg::S_CLEAR) begin
			wr_en   = 1'b1;
			wr_addr = clr_cnt_q;
			wr_data = pfdr_pkg::FILL_BYTE;
		end else if (state_q == pfdr_pkg::S_READ && op_q == pfdr_pkg::OP_WRITE && inside_q) begin
			wr_en = 1'b1;
		end
	end

	pfdr_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pfdr_pkg::S_CLEAR;
			clr_cnt_q    <= '0;
			clr_report_q <= 1'b0;
			dirty_fp_q   <= PAGE_LAST;
			dirty_lp_q   <= '0;
			dirty_fc_q   <= COL_LAST;
			dirty_lc_q   <= '0;
			busy_q       <= 1'b0;
			drain_fp_q   <= '0;
			drain_lp_q   <= '0;
			drain_fc_q   <= '0;
			drain_lc_q   <= '0;
			drain_page_q <= '0;
			drain_col_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				pfdr_pkg::S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == ADDR_LAST) begin
						clr_cnt_q <= '0;
						state_q   <= clr_report_q ? pfdr_pkg::S_READ : pfdr_pkg::S_IDLE;
					end
				end
				pfdr_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= pfdr_pkg::S_READ;
						unique case (in_op)
							pfdr_pkg::OP_WRITE: begin
								if (in_inside) begin
									if (in_pg < dirty_fp_q) dirty_fp_q <= in_pg;
									if (in_pg > dirty_lp_q) dirty_lp_q <= in_pg;
									if (in_col < dirty_fc_q) dirty_fc_q <= in_col;
									if (in_col > dirty_lc_q) dirty_lc_q <= in_col;
								end
							end
							pfdr_pkg::OP_READ: begin
							end
							pfdr_pkg::OP_REFRESH: begin
								if (!busy_q) begin
									drain_fp_q <= dirty_fp_q;
									drain_lp_q <= dirty_lp_q;
									drain_fc_q <= dirty_fc_q;
									drain_lc_q <= dirty_lc_q;
									dirty_fp_q <= PAGE_LAST;
									dirty_lp_q <= '0;
									dirty_fc_q <= COL_LAST;
									dirty_lc_q <= '0;
									if (!dirty_empty) begin
										busy_q       <= 1'b1;
										drain_page_q <= dirty_fp_q;
										drain_col_q  <= dirty_fc_q;
									end
								end
							end
							pfdr_pkg::OP_CLEAR: begin
								dirty_fp_q   <= PAGE_LAST;
								dirty_lp_q   <= '0;
								dirty_fc_q   <= COL_LAST;
								dirty_lc_q   <= '0;
								busy_q       <= 1'b0;
								clr_report_q <= 1'b1;
								clr_cnt_q    <= '0;
								state_q      <= pfdr_pkg::S_CLEAR;
							end
						endcase
					end
				end
				pfdr_pkg::S_READ: begin
					if (op_q == pfdr_pkg::OP_WRITE && !clr_report_q) begin
						state_q <= pfdr_pkg::S_IDLE;
					end else if (out_free) begin
						state_q      <= pfdr_pkg::S_IDLE;
						out_valid_q  <= 1'b1;
						clr_report_q <= 1'b0;
						if (!clr_report_q && op_q == pfdr_pkg::OP_REFRESH && !empty_q) begin
							if (fin) begin
								busy_q <= 1'b0;
							end else if (drain_col_q == drain_lc_q) begin
								drain_col_q  <= drain_fc_q;
								drain_page_q <= drain_page_q + PW'(1);
							end else begin
								drain_col_q <= drain_col_q + CW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= pfdr_pkg::S_IDLE;
				end
			endcase
		end
	end

	// request payload and result register
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= in_op;
			y_lo_q   <= in_y[2:0];
			color_q  <= in_color;
			inside_q <= in_inside;
			addr_q   <= rd_addr;
			empty_q  <= !busy_q && dirty_empty;
		end
		if (emit) begin
			out_kind_q    <= pfdr_pkg::KIND_PIXEL;
			out_pixel_q   <= 1'b0;
			out_byte_q    <= '0;
			out_col_q     <= '0;
			out_page_q    <= '0;
			out_new_row_q <= 1'b0;
			out_last_q    <= 1'b0;
			if (clr_report_q || op_q == pfdr_pkg::OP_CLEAR) begin
				out_kind_q <= pfdr_pkg::KIND_FILL;
			end else if (op_q == pfdr_pkg::OP_READ) begin
				out_pixel_q <= inside_q ? rd_data[y_lo_q] : 1'b0;
			end else if (empty_q) begin
				out_kind_q <= pfdr_pkg::KIND_IDLE;
			end else begin
				out_kind_q    <= pfdr_pkg::KIND_DATA;
				out_byte_q    <= rd_data;
				out_col_q     <= col_ext[6:0];
				out_page_q    <= page_ext[2:0];
				out_new_row_q <= row_start;
				out_last_q    <= fin;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {4'b0000, out_new_row_q, out_page_q, out_col_q, out_byte_q,
	                        out_pixel_q};

	a_drain_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (drain_page_q >= drain_fp_q && drain_page_q <= drain_lp_q
		            && drain_col_q >= drain_fc_q && drain_col_q <= drain_lc_q))
		else $error("drain position outside latched rectangle");

	a_busy_from_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy_q) |-> $past(accept && in_op == pfdr_pkg::OP_REFRESH))
		else $error("drain started without a refresh request");

	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == pfdr_pkg::S_READ))
		else $error("result loaded outside the result cycle");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pfdr_pkg::S_CLEAR) |-> (wr_en && !rd_en))
		else $error("store access during clearing sweep");

endmodule
